// ----- sv/amr_pkg.sv -----
// Package with the constants and helper functions of the matrix axis reduction block.
package amr_pkg;
    localparam int MAX_ROWS  = 4096;
    localparam int MAX_COLS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 32;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int FLAT_W    = ROW_W + COL_W + 1;
    localparam int DIV_W     = 34;

    localparam logic [2:0] OP_SUM  = 3'd0;
    localparam logic [2:0] OP_MEAN = 3'd1;
    localparam logic [2:0] OP_MIN  = 3'd2;
    localparam logic [2:0] OP_MAX  = 3'd3;
    localparam logic [2:0] OP_PROD = 3'd4;

    localparam logic [1:0] AX_WHOLE = 2'd0;
    localparam logic [1:0] AX_COL   = 2'd1;
    localparam logic [1:0] AX_ROW   = 2'd2;

    localparam logic [1:0] REG_OP   = 2'd0;
    localparam logic [1:0] REG_AXIS = 2'd1;
    localparam logic [1:0] REG_ROWS = 2'd2;
    localparam logic [1:0] REG_COLS = 2'd3;

    typedef logic signed [ACC_W-1:0] t_acc;

    function automatic t_acc start_value(input logic [2:0] op);
        t_acc v;
        v = '0;
        unique case (op)
            OP_MIN:  v = {1'b0, {(ACC_W-1){1'b1}}};
            OP_MAX:  v = {1'b1, {(ACC_W-1){1'b0}}};
            OP_PROD: v = t_acc'(64'd1 << FRAC_BITS);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_acc sat_value(input logic signed [63:0] v, output logic clip);
        t_acc r;
        clip = 1'b0;
        r = v[ACC_W-1:0];
        if (v > 64'sh7FFFFFFF) begin
            clip = 1'b1;
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (v < -64'sh80000000) begin
            clip = 1'b1;
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end
        return r;
    endfunction
endpackage

// ----- sv/axis_matrix_reduction.sv -----
// Top level of the matrix axis reduction block.
// Elements arrive row-major as signed Q16.16 words on the input channel
// (i_elem_valid / o_elem_stall). Each word is folded into an accumulator
// selected by the axis mode, using sum, running mean, minimum, maximum or
// product with saturation. Results leave on the output channel
// (o_result_valid / i_result_stall) together with their row or column
// position, a clip flag and a last flag.
// A word passes the read, wait, calc and write states after acceptance before
// the next word can be taken; product adds a multiply state and mean a divide
// state, where a shared restoring divider resolves one quotient bit per cycle.
// Whole mode then presents one result word per matrix and row mode one per
// row. Column mode reads the accumulator memory back after the final element,
// one result word per column, each through read, wait and output states.
// At the start of each matrix the 64 accumulators are set to the start
// value by a sweep of one entry per cycle.
// Reset clears the configuration to sum, whole matrix, one by one, and
// restarts the matrix. When the receiver stalls, the result word holds and
// no new element word is taken. Configuration writes restart the matrix and
// the user must make them only while the block is idle; the block does not enforce it.
module axis_matrix_reduction (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [12:0]                      i_cfg_data,
    input  logic                             i_elem_valid,
    output logic                             o_elem_stall,
    input  logic signed [amr_pkg::ACC_W-1:0] i_elem_value,
    output logic                             o_result_valid,
    input  logic                             i_result_stall,
    output logic signed [amr_pkg::ACC_W-1:0] o_result_value,
    output logic [11:0]                      o_result_position,
    output logic                             o_saturated,
    output logic                             o_last
);
    import amr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_DRD   = 4'd9;
    localparam logic [3:0] S_DWT   = 4'd10;
    localparam logic [3:0] S_DOUT  = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_op;
    logic [1:0]  r_axis;
    logic [12:0] r_rows;
    logic [6:0]  r_cols;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [FLAT_W-1:0] r_flat;
    logic [COL_W:0]    r_sweep;
    t_acc r_val;
    t_acc r_acc;
    logic r_clip;
    logic signed [63:0] r_prod;
    logic [DIV_W-1:0] r_rem, r_quo, r_den;
    logic r_dneg;
    logic [5:0] r_dcnt;
    logic [COL_W-1:0] r_slot;
    logic r_row_end, r_mat_end;
    logic [11:0] r_pos;

    logic [2:0]  eff_op;
    logic [1:0]  eff_axis;
    logic [12:0] eff_rows;
    logic [6:0]  eff_cols;
    logic        ram_we;
    logic [COL_W-1:0] ram_addr;
    logic [ACC_W:0] ram_wdata, ram_rdata;
    logic signed [63:0] diff;
    logic [DIV_W:0] rem_try;
    logic sat_c;
    t_acc sat_r;
    logic signed [63:0] sat_in;
    logic [63:0] pmag;

    always_comb begin
        eff_op   = (r_op > OP_PROD) ? OP_SUM : r_op;
        eff_axis = (r_axis == 2'd3) ? AX_WHOLE : r_axis;
        eff_rows = (r_rows == '0) ? 13'd1 :
                   (r_rows > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : r_rows;
        eff_cols = (r_cols == '0) ? 7'd1 :
                   (r_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : r_cols;
    end

    amr_ram #(.WIDTH(ACC_W + 1), .DEPTH(MAX_COLS)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_slot;
        ram_wdata = {r_clip, r_acc};
        priority case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_sweep[COL_W-1:0];
                ram_wdata = {1'b0, start_value(eff_op)};
            end
            S_WRITE: ram_we = 1'b1;
            S_DRD, S_DWT, S_DOUT: ram_addr = r_sweep[COL_W-1:0];
            default: ram_addr = r_slot;
        endcase
    end

    always_comb begin
        diff    = 64'(r_val) - 64'(r_acc);
        rem_try = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_den};
        pmag    = r_prod[63] ? (64'd0 - r_prod) : r_prod;
        pmag    = pmag >> FRAC_BITS;
        sat_in  = 64'(r_acc) + 64'(r_val);
        priority case (r_state)
            S_DIV: sat_in = 64'(r_acc) + (r_dneg ? -64'($signed({1'b0, r_quo}))
                                                 : 64'($signed({1'b0, r_quo})));
            S_MUL: sat_in = r_prod[63] ? -$signed(pmag) : $signed(pmag);
            default: sat_in = 64'(r_acc) + 64'(r_val);
        endcase
        sat_r = sat_value(sat_in, sat_c);
    end

    assign o_elem_stall = (r_state != S_IDLE) || i_cfg_we;
    assign o_result_valid = (r_state == S_OUT) || (r_state == S_DOUT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_elem_valid && !o_elem_stall) begin
                         n_state = (r_row == '0 && r_col == '0) ? S_CLEAR : S_READ;
                     end
            S_CLEAR: if (r_sweep[COL_W-1:0] == COL_W'(MAX_COLS - 1)) n_state = S_READ;
            S_READ:  n_state = S_WAIT;
            S_WAIT:  n_state = S_CALC;
            S_CALC:  begin
                         unique case (eff_op)
                             OP_MEAN: n_state = S_DIV;
                             OP_PROD: n_state = S_MUL;
                             default: n_state = S_WRITE;
                         endcase
                     end
            S_DIV:   if (r_dcnt == '0) n_state = S_WRITE;
            S_MUL:   n_state = S_WRITE;
            S_WRITE: begin
                         if (eff_axis == AX_COL) begin
                             n_state = r_mat_end ? S_DRD : S_IDLE;
                         end else begin
                             n_state = (r_mat_end || (eff_axis == AX_ROW && r_row_end))
                                     ? S_OUT : S_IDLE;
                         end
                     end
            S_OUT:   if (!i_result_stall) n_state = S_IDLE;
            S_DRD:   n_state = S_DWT;
            S_DWT:   n_state = S_DOUT;
            S_DOUT:  if (!i_result_stall) begin
                         n_state = (r_sweep == {1'b0, eff_cols[COL_W-1:0]} - 1'b1
                                    || 7'(r_sweep) + 7'd1 == eff_cols) ? S_IDLE : S_DRD;
                     end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_SUM;
            r_axis  <= AX_WHOLE;
            r_rows  <= 13'd1;
            r_cols  <= 7'd1;
            r_row   <= '0;
            r_col   <= '0;
            r_flat  <= '0;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OP:   r_op   <= i_cfg_data[2:0];
                    REG_AXIS: r_axis <= i_cfg_data[1:0];
                    REG_ROWS: r_rows <= i_cfg_data;
                    REG_COLS: r_cols <= i_cfg_data[6:0];
                    default:  r_op   <= r_op;
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_flat <= '0;
            end
            unique case (r_state)
                S_CLEAR: r_sweep <= r_sweep + 1'b1;
                S_WRITE: begin
                    r_sweep <= '0;
                    if (r_mat_end) begin
                        r_row  <= '0;
                        r_col  <= '0;
                        r_flat <= '0;
                    end else begin
                        r_flat <= r_flat + 1'b1;
                        if (r_row_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_DOUT: if (!i_result_stall) r_sweep <= r_sweep + 1'b1;
                default: r_sweep <= (r_state == S_IDLE) ? '0 : r_sweep;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_val     <= i_elem_value;
                r_slot    <= (eff_axis == AX_COL) ? r_col : '0;
                r_pos     <= 12'(r_row);
                r_row_end <= (7'(r_col) + 7'd1 == eff_cols);
                r_mat_end <= (7'(r_col) + 7'd1 == eff_cols)
                             && (13'(r_row) + 13'd1 == eff_rows);
                unique case (eff_axis)
                    AX_COL:  r_den <= DIV_W'(r_row) + 1'b1;
                    AX_ROW:  r_den <= DIV_W'(r_col) + 1'b1;
                    default: r_den <= DIV_W'(r_flat) + 1'b1;
                endcase
            end
            S_WAIT: begin
                if (eff_axis == AX_ROW && r_col == '0) begin
                    r_acc  <= start_value(eff_op);
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= ram_rdata[ACC_W-1:0];
                    r_clip <= ram_rdata[ACC_W];
                end
            end
            S_CALC: begin
                r_prod <= 64'(r_acc) * 64'(r_val);
                r_dneg <= diff[63];
                r_quo  <= diff[63] ? DIV_W'(-diff) : DIV_W'(diff);
                r_rem  <= '0;
                r_dcnt <= 6'(DIV_W);
                unique case (eff_op)
                    OP_MIN:  if (r_val < r_acc) r_acc <= r_val;
                    OP_MAX:  if (r_val > r_acc) r_acc <= r_val;
                    OP_SUM, OP_MEAN, OP_PROD: begin
                        if (eff_op == OP_SUM) begin
                            r_acc  <= sat_r;
                            r_clip <= r_clip | sat_c;
                        end
                    end
                    default: r_acc <= r_acc;
                endcase
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    r_dcnt <= r_dcnt - 1'b1;
                    if (!rem_try[DIV_W]) begin
                        r_rem <= rem_try[DIV_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                end else begin
                    r_acc  <= sat_r;
                    r_clip <= r_clip | sat_c;
                end
            end
            S_MUL: begin
                r_acc  <= sat_r;
                r_clip <= r_clip | sat_c;
            end
            S_DWT: begin
                r_acc  <= ram_rdata[ACC_W-1:0];
                r_clip <= ram_rdata[ACC_W];
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_result_value    = r_acc;
    assign o_saturated       = r_clip;
    assign o_result_position = (r_state == S_DOUT) ? 12'(r_sweep)
                             : (eff_axis == AX_ROW) ? r_pos : 12'd0;
    assign o_last = (r_state == S_DOUT) ? (7'(r_sweep) + 7'd1 == eff_cols) : r_mat_end;
endmodule

// ----- sv/amr_ram.sv -----
// Generic single-port RAM with a registered read.
module amr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/amr_checker.sv -----
// Port-level checker for the matrix axis reduction block and its binding.
module amr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_elem_valid,
    input logic        o_elem_stall,
    input logic        o_result_valid,
    input logic        i_result_stall,
    input logic [31:0] o_result_value,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_stall |=> o_result_valid && $stable(o_result_value)
                                            && $stable(o_last))
        else $error("result word changed under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> o_elem_stall)
        else $error("element word taken while a result waits");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_elem_valid && !o_elem_stall |=> o_elem_stall)
        else $error("element word taken on consecutive cycles");
endmodule

bind axis_matrix_reduction amr_checker u_amr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_elem_valid  (i_elem_valid),
    .o_elem_stall  (o_elem_stall),
    .o_result_valid(o_result_valid),
    .i_result_stall(i_result_stall),
    .o_result_value(o_result_value),
    .o_last        (o_last)
);
